[hdl/ssg_pkg.sv]
// ----------------------------------------------------------------------------
// Spectral subtraction gain package
// Shared widths, codes, payload types and per-bin state layout.
// ----------------------------------------------------------------------------
package ssg_pkg;

    localparam int DATA_W     = 24;
    localparam int GAIN_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_COEF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_COEF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_ALPHA = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FLOOR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RESID_THR   = 3'd7;

    // control flag bits
    localparam int FLAG_ON    = 0;
    localparam int FLAG_SNR   = 1;
    localparam int FLAG_RESID = 2;

    // magnitude smoothing modes
    localparam logic [1:0] SM_MAG = 2'd1;
    localparam logic [1:0] SM_PWR = 2'd2;

    // gain rules
    localparam logic [3:0] GM_DEFAULT     = 4'd0;
    localparam logic [3:0] GM_MAG_RN      = 4'd1;
    localparam logic [3:0] GM_MAG_RS      = 4'd2;
    localparam logic [3:0] GM_MAG_RQ      = 4'd3;
    localparam logic [3:0] GM_MAG_FLOOR_Q = 4'd4;
    localparam logic [3:0] GM_PWR_FLOOR   = 4'd5;
    localparam logic [3:0] GM_PWR_RN      = 4'd6;
    localparam logic [3:0] GM_PWR_RS      = 4'd7;
    localparam logic [3:0] GM_PWR_RQ      = 4'd8;
    localparam logic [3:0] GM_PWR_FLOOR_Q = 4'd9;

    localparam logic [GAIN_W-1:0] Q16_ONE    = 17'h10000;
    localparam logic [15:0]       ALPHA_ONE  = 16'd8192;
    localparam logic [15:0]       ALPHA_FOUR = 16'd32768;
    localparam logic [13:0]       COEF_P15   = 14'd9830;
    localparam logic [39:0]       SNR_HI     = 40'd1310720;
    localparam logic [39:0]       SNR_LO     = 40'd262144;
    localparam logic [31:0]       RATIO_CAP  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [DATA_W-1:0] bin_re;
        logic signed [DATA_W-1:0] bin_im;
        logic                     last_bin;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_re;
        logic signed [DATA_W-1:0] out_im;
        logic [GAIN_W-1:0]        gain_applied;
        logic                     last_out;
    } out_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]        min_cur;
        logic [DATA_W-1:0]        min_p1;
        logic [DATA_W-1:0]        min_p2;
        logic [DATA_W-1:0]        min_p3;
        logic [DATA_W-1:0]        smag;
        logic [DATA_W-1:0]        snoise;
        logic signed [DATA_W-1:0] pout_re;
        logic signed [DATA_W-1:0] pout_im;
    } bin_state_t;

    localparam bin_state_t BIN_STATE_RESET = '{
        min_cur: '1, min_p1: '1, min_p2: '1, min_p3: '1,
        smag: '0, snoise: '0, pout_re: '0, pout_im: '0
    };

endpackage

[hdl/spectral_subtraction_gain_top.sv]
// ----------------------------------------------------------------------------
// Spectral subtraction gain
// Per-bin noise suppression with minimum-statistics noise tracking.
// ----------------------------------------------------------------------------
// One bin is processed at a time. With processing off a bin passes through
// with unity gain. With processing on, the magnitude root and every other
// root go through a 2-bit-per-cycle square root unit, the three gain ratios
// and the SNR quotient go through a bit-serial divider, and the remaining
// products share one multiplier, one per cycle. All per-bin state sits in
// one memory with a registered read port; after reset a clearing pass
// initializes every entry, during which in_stall is held high. A finished
// bin waits in the output register while the next one is already accepted.
module spectral_subtraction_gain_top #(
    parameter int NUM_BINS           = 256,
    parameter int FRAMES_PER_SEGMENT = 79
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ssg_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ssg_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [ssg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int FC_W = $clog2(FRAMES_PER_SEGMENT);
    localparam logic [AW-1:0]   BIN_LAST = AW'(NUM_BINS - 1);
    localparam logic [FC_W-1:0] FC_LAST  = FC_W'(FRAMES_PER_SEGMENT - 1);

    localparam int ST_W = 6;
    localparam logic [ST_W-1:0] S_CLR  = 6'd0;
    localparam logic [ST_W-1:0] S_IDLE = 6'd1;
    localparam logic [ST_W-1:0] S_READ = 6'd2;
    localparam logic [ST_W-1:0] S_LOAD = 6'd3;
    localparam logic [ST_W-1:0] S_SQ1  = 6'd4;
    localparam logic [ST_W-1:0] S_SQ2  = 6'd5;
    localparam logic [ST_W-1:0] S_SQRT = 6'd6;
    localparam logic [ST_W-1:0] S_MAGD = 6'd7;
    localparam logic [ST_W-1:0] S_SMA  = 6'd8;
    localparam logic [ST_W-1:0] S_SMB  = 6'd9;
    localparam logic [ST_W-1:0] S_PA   = 6'd10;
    localparam logic [ST_W-1:0] S_PB   = 6'd11;
    localparam logic [ST_W-1:0] S_PC   = 6'd12;
    localparam logic [ST_W-1:0] S_PD   = 6'd13;
    localparam logic [ST_W-1:0] S_PE   = 6'd14;
    localparam logic [ST_W-1:0] S_PF   = 6'd15;
    localparam logic [ST_W-1:0] S_PG   = 6'd16;
    localparam logic [ST_W-1:0] S_MIN  = 6'd17;
    localparam logic [ST_W-1:0] S_DIV  = 6'd18;
    localparam logic [ST_W-1:0] S_SNR  = 6'd19;
    localparam logic [ST_W-1:0] S_NZ   = 6'd20;
    localparam logic [ST_W-1:0] S_NSA  = 6'd21;
    localparam logic [ST_W-1:0] S_NSB  = 6'd22;
    localparam logic [ST_W-1:0] S_DRN  = 6'd23;
    localparam logic [ST_W-1:0] S_RN   = 6'd24;
    localparam logic [ST_W-1:0] S_RS   = 6'd25;
    localparam logic [ST_W-1:0] S_RQ   = 6'd26;
    localparam logic [ST_W-1:0] S_GL   = 6'd27;
    localparam logic [ST_W-1:0] S_GP   = 6'd28;
    localparam logic [ST_W-1:0] S_GR   = 6'd29;
    localparam logic [ST_W-1:0] S_GM   = 6'd30;
    localparam logic [ST_W-1:0] S_OA   = 6'd31;
    localparam logic [ST_W-1:0] S_OB   = 6'd32;
    localparam logic [ST_W-1:0] S_R1   = 6'd33;
    localparam logic [ST_W-1:0] S_R2   = 6'd34;
    localparam logic [ST_W-1:0] S_R3   = 6'd35;
    localparam logic [ST_W-1:0] S_R4   = 6'd36;
    localparam logic [ST_W-1:0] S_WB   = 6'd37;
    localparam logic [ST_W-1:0] S_DONE = 6'd38;

    function automatic logic [23:0] abs24(input logic signed [23:0] v);
        logic [23:0] u;
        u = v;
        return u[23] ? (~u + 24'd1) : u;
    endfunction

    // control and configuration
    logic [ST_W-1:0] state_reg, ret_reg;
    logic [5:0]      it_reg;
    logic [AW-1:0]   clr_idx_reg, bin_pos_reg, bin_reg;
    logic [FC_W-1:0] fc_reg;
    logic [15:0]     alpha_reg;
    logic            out_valid_reg;
    logic [2:0]      ctrl_reg;
    logic [1:0]      smooth_mode_reg;
    logic [3:0]      gain_mode_reg;
    logic [15:0]     mag_coef_reg, noise_coef_reg, fixed_alpha_reg;
    logic [15:0]     gain_floor_reg, resid_thr_reg;

    // datapath
    ssg_pkg::in_item_t  in_reg;
    ssg_pkg::out_item_t out_reg;
    ssg_pkg::bin_state_t ws_reg, rd_word_reg;
    logic [23:0]        mag_reg, sm_reg, sn_reg, nmin_reg, noise_reg;
    logic [31:0]        rn_reg, rs_reg, rq_reg, left_reg;
    logic [16:0]        right_reg, gain_reg;
    logic signed [23:0] ore_reg, oim_reg;
    logic [63:0]        acc_reg;
    logic [47:0]        t_reg;

    // square root unit
    logic [47:0] sq_val_reg;
    logic [24:0] sq_rem_reg;
    logic [23:0] sq_root_reg;
    logic [26:0] sq_rem_sh, sq_trial;
    logic        sq_ge;

    // divider unit
    logic [39:0] dv_reg;
    logic [23:0] dr_rem_reg, dd_reg;
    logic [24:0] dv_rem_sh;
    logic        dv_ge;
    logic [31:0] q_sat;

    // memory
    ssg_pkg::bin_state_t mem [NUM_BINS];
    ssg_pkg::bin_state_t mem_wdata;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    logic [16:0] w_mag, w_noise;
    logic        smoothing, rotate, lscale, pwr_rule;
    logic [23:0] x_val, cur_min, nmin_next;
    ssg_pkg::bin_state_t ws_next;
    logic [31:0] lratio, rratio;
    logic [31:0] gain_max;
    logic [47:0] pn_prev;

    assign w_mag     = ssg_pkg::Q16_ONE - {1'b0, mag_coef_reg};
    assign w_noise   = ssg_pkg::Q16_ONE - {1'b0, noise_coef_reg};
    assign smoothing = (smooth_mode_reg == ssg_pkg::SM_MAG) ||
                       (smooth_mode_reg == ssg_pkg::SM_PWR);
    assign rotate    = (fc_reg == FC_LAST);
    assign prod      = 64'(mul_a) * 64'(mul_b);

    // running minima and segment rotation
    always_comb
    begin
        x_val   = smoothing ? sm_reg : mag_reg;
        cur_min = (ws_reg.min_cur < x_val) ? ws_reg.min_cur : x_val;
        ws_next = ws_reg;
        if (rotate)
        begin
            ws_next.min_p3  = ws_reg.min_p2;
            ws_next.min_p2  = ws_reg.min_p1;
            ws_next.min_p1  = cur_min;
            ws_next.min_cur = x_val;
        end
        else
        begin
            ws_next.min_cur = cur_min;
        end
        nmin_next = ws_next.min_cur;
        if (ws_next.min_p1 < nmin_next) nmin_next = ws_next.min_p1;
        if (ws_next.min_p2 < nmin_next) nmin_next = ws_next.min_p2;
        if (ws_next.min_p3 < nmin_next) nmin_next = ws_next.min_p3;
    end

    // gain rule decode
    always_comb
    begin
        lscale = gain_mode_reg inside {ssg_pkg::GM_MAG_RN, ssg_pkg::GM_PWR_RN,
                                       ssg_pkg::GM_MAG_RS, ssg_pkg::GM_PWR_RS,
                                       ssg_pkg::GM_MAG_RQ, ssg_pkg::GM_PWR_RQ};
        if (gain_mode_reg inside {ssg_pkg::GM_MAG_RN, ssg_pkg::GM_PWR_RN})
            lratio = rn_reg;
        else if (gain_mode_reg inside {ssg_pkg::GM_MAG_RS, ssg_pkg::GM_PWR_RS})
            lratio = rs_reg;
        else
            lratio = rq_reg;
        rratio = (gain_mode_reg inside {ssg_pkg::GM_MAG_RQ, ssg_pkg::GM_MAG_FLOOR_Q,
                                        ssg_pkg::GM_PWR_RQ, ssg_pkg::GM_PWR_FLOOR_Q})
                 ? rq_reg : rn_reg;
        pwr_rule = gain_mode_reg inside {ssg_pkg::GM_PWR_FLOOR, ssg_pkg::GM_PWR_RN,
                                         ssg_pkg::GM_PWR_RS, ssg_pkg::GM_PWR_RQ,
                                         ssg_pkg::GM_PWR_FLOOR_Q};
        gain_max = (left_reg > {15'd0, right_reg}) ? left_reg : {15'd0, right_reg};
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ1: begin mul_a = 32'(abs24(in_reg.bin_re)); mul_b = mul_a; end
            S_SQ2: begin mul_a = 32'(abs24(in_reg.bin_im)); mul_b = mul_a; end
            S_SMA: begin mul_a = 32'(mag_reg);       mul_b = 32'(w_mag); end
            S_SMB: begin mul_a = 32'(sm_reg);        mul_b = 32'(mag_coef_reg); end
            S_PA:  begin mul_a = 32'(mag_reg);       mul_b = 32'(mag_reg); end
            S_PB:  begin mul_a = 32'(t_reg[23:0]);   mul_b = 32'(w_mag); end
            S_PC:  begin mul_a = 32'(t_reg[47:24]);  mul_b = 32'(w_mag); end
            S_PD:  begin mul_a = 32'(sm_reg);        mul_b = 32'(sm_reg); end
            S_PE:  begin mul_a = 32'(t_reg[23:0]);   mul_b = 32'(mag_coef_reg); end
            S_PF:  begin mul_a = 32'(t_reg[47:24]);  mul_b = 32'(mag_coef_reg); end
            S_SNR: begin mul_a = 32'(dv_reg[20:0]);  mul_b = 32'(ssg_pkg::COEF_P15); end
            S_NZ:  begin mul_a = 32'(nmin_reg);      mul_b = 32'(alpha_reg); end
            S_NSA: begin mul_a = 32'(noise_reg);     mul_b = 32'(w_noise); end
            S_NSB: begin mul_a = 32'(sn_reg);        mul_b = 32'(noise_coef_reg); end
            S_GL:  begin mul_a = 32'(gain_floor_reg); mul_b = lratio; end
            S_GP:  begin mul_a = 32'(rratio[15:0]);  mul_b = 32'(rratio[15:0]); end
            S_OA:  begin mul_a = 32'(abs24(in_reg.bin_re)); mul_b = 32'(gain_reg); end
            S_OB:  begin mul_a = 32'(abs24(in_reg.bin_im)); mul_b = 32'(gain_reg); end
            S_R1:  begin mul_a = 32'(abs24(ore_reg)); mul_b = mul_a; end
            S_R2:  begin mul_a = 32'(abs24(oim_reg)); mul_b = mul_a; end
            S_R3:  begin mul_a = 32'(abs24(ws_reg.pout_re)); mul_b = mul_a; end
            S_R4:  begin mul_a = 32'(abs24(ws_reg.pout_im)); mul_b = mul_a; end
            default: ;
        endcase
    end

    // one root bit and one quotient bit per step
    always_comb
    begin
        sq_rem_sh = {sq_rem_reg, sq_val_reg[47:46]};
        sq_trial  = {1'b0, sq_root_reg, 2'b01};
        sq_ge     = (sq_rem_sh >= sq_trial);
        dv_rem_sh = {dr_rem_reg, dv_reg[39]};
        dv_ge     = (dv_rem_sh >= {1'b0, dd_reg});
        q_sat     = (dv_reg[39:32] != 8'd0) ? ssg_pkg::RATIO_CAP : dv_reg[31:0];
        pn_prev   = t_reg + prod[47:0];
    end

    // memory write port: clearing pass or per-bin write-back
    always_comb
    begin
        mem_we    = (state_reg == S_CLR) || (state_reg == S_WB);
        mem_waddr = (state_reg == S_CLR) ? clr_idx_reg : bin_reg;
        mem_wdata = ssg_pkg::BIN_STATE_RESET;
        if (state_reg != S_CLR)
        begin
            mem_wdata        = ws_reg;
            mem_wdata.smag   = sm_reg;
            mem_wdata.snoise = sn_reg;
            if (ctrl_reg[ssg_pkg::FLAG_RESID])
            begin
                mem_wdata.pout_re = ore_reg;
                mem_wdata.pout_im = oim_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_word_reg <= mem[bin_reg];
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // control, configuration and sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            ret_reg         <= S_IDLE;
            it_reg          <= '0;
            clr_idx_reg     <= '0;
            bin_pos_reg     <= '0;
            fc_reg          <= '0;
            alpha_reg       <= ssg_pkg::ALPHA_FOUR;
            out_valid_reg   <= 1'b0;
            ctrl_reg        <= 3'd1;
            smooth_mode_reg <= 2'd0;
            gain_mode_reg   <= ssg_pkg::GM_DEFAULT;
            mag_coef_reg    <= 16'd59299;
            noise_coef_reg  <= 16'd0;
            fixed_alpha_reg <= 16'd32768;
            gain_floor_reg  <= 16'd6554;
            resid_thr_reg   <= 16'd2560;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    ssg_pkg::REG_CONTROL:     ctrl_reg        <= cfg_wdata[2:0];
                    ssg_pkg::REG_SMOOTH_MODE: smooth_mode_reg <= cfg_wdata[1:0];
                    ssg_pkg::REG_GAIN_MODE:   gain_mode_reg   <= cfg_wdata[3:0];
                    ssg_pkg::REG_MAG_COEF:    mag_coef_reg    <= cfg_wdata;
                    ssg_pkg::REG_NOISE_COEF:  noise_coef_reg  <= cfg_wdata;
                    ssg_pkg::REG_FIXED_ALPHA: fixed_alpha_reg <= cfg_wdata;
                    ssg_pkg::REG_GAIN_FLOOR:  gain_floor_reg  <= cfg_wdata;
                    ssg_pkg::REG_RESID_THR:   resid_thr_reg   <= cfg_wdata;
                    default: ;
                endcase
            end

            if ((state_reg == S_DONE) && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == BIN_LAST)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        bin_pos_reg <= (in_data.last_bin || bin_pos_reg == BIN_LAST)
                                       ? '0 : bin_pos_reg + 1'b1;
                        state_reg <= ctrl_reg[ssg_pkg::FLAG_ON] ? S_READ : S_DONE;
                    end
                end
                S_READ: state_reg <= S_LOAD;
                S_LOAD: state_reg <= S_SQ1;
                S_SQ1:  state_reg <= S_SQ2;
                S_SQ2:
                begin
                    it_reg    <= 6'd23;
                    ret_reg   <= S_MAGD;
                    state_reg <= S_SQRT;
                end
                S_SQRT, S_DIV:
                begin
                    if (it_reg == 6'd0)
                        state_reg <= ret_reg;
                    else
                        it_reg <= it_reg - 1'b1;
                end
                S_MAGD:
                begin
                    if (smooth_mode_reg == ssg_pkg::SM_MAG)
                        state_reg <= S_SMA;
                    else if (smooth_mode_reg == ssg_pkg::SM_PWR)
                        state_reg <= S_PA;
                    else
                        state_reg <= S_MIN;
                end
                S_SMA: state_reg <= S_SMB;
                S_SMB: state_reg <= S_MIN;
                S_PA:  state_reg <= S_PB;
                S_PB:  state_reg <= S_PC;
                S_PC:  state_reg <= S_PD;
                S_PD:  state_reg <= S_PE;
                S_PE:  state_reg <= S_PF;
                S_PF:
                begin
                    it_reg    <= 6'd23;
                    ret_reg   <= S_PG;
                    state_reg <= S_SQRT;
                end
                S_PG: state_reg <= S_MIN;
                S_MIN:
                begin
                    if (!ctrl_reg[ssg_pkg::FLAG_SNR])
                    begin
                        alpha_reg <= fixed_alpha_reg;
                        state_reg <= S_NZ;
                    end
                    else if (nmin_next == 24'd0)
                    begin
                        alpha_reg <= ssg_pkg::ALPHA_ONE;
                        state_reg <= S_NZ;
                    end
                    else if (mag_reg >= nmin_next)
                    begin
                        it_reg    <= 6'd39;
                        ret_reg   <= S_SNR;
                        state_reg <= S_DIV;
                    end
                    else
                        state_reg <= S_NZ;
                end
                S_SNR:
                begin
                    if (dv_reg >= ssg_pkg::SNR_HI)
                        alpha_reg <= ssg_pkg::ALPHA_ONE;
                    else if (dv_reg > ssg_pkg::SNR_LO)
                        alpha_reg <= ssg_pkg::ALPHA_FOUR - prod[34:19];
                    state_reg <= S_NZ;
                end
                S_NZ:  state_reg <= S_NSA;
                S_NSA: state_reg <= S_NSB;
                S_NSB: state_reg <= S_DRN;
                S_DRN:
                begin
                    it_reg    <= 6'd39;
                    ret_reg   <= S_RN;
                    state_reg <= S_DIV;
                end
                S_RN:
                begin
                    it_reg    <= 6'd39;
                    ret_reg   <= S_RS;
                    state_reg <= S_DIV;
                end
                S_RS:
                begin
                    it_reg    <= 6'd39;
                    ret_reg   <= S_RQ;
                    state_reg <= S_DIV;
                end
                S_RQ: state_reg <= S_GL;
                S_GL: state_reg <= pwr_rule ? S_GP : S_GM;
                S_GP:
                begin
                    if (rratio >= 32'h0001_0000)
                        state_reg <= S_GM;
                    else
                    begin
                        it_reg    <= 6'd23;
                        ret_reg   <= S_GR;
                        state_reg <= S_SQRT;
                    end
                end
                S_GR: state_reg <= S_GM;
                S_GM: state_reg <= S_OA;
                S_OA: state_reg <= S_OB;
                S_OB:
                begin
                    if (ctrl_reg[ssg_pkg::FLAG_RESID] && (rn_reg > {8'd0, resid_thr_reg, 8'd0}))
                        state_reg <= S_R1;
                    else
                        state_reg <= S_WB;
                end
                S_R1: state_reg <= S_R2;
                S_R2: state_reg <= S_R3;
                S_R3: state_reg <= S_R4;
                S_R4: state_reg <= S_WB;
                S_WB:
                begin
                    if (in_reg.last_bin)
                        fc_reg <= rotate ? '0 : fc_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                in_reg   <= in_data;
                bin_reg  <= bin_pos_reg;
                ore_reg  <= in_data.bin_re;
                oim_reg  <= in_data.bin_im;
                gain_reg <= ssg_pkg::Q16_ONE;
            end
            S_LOAD:
            begin
                ws_reg <= rd_word_reg;
                sm_reg <= rd_word_reg.smag;
                sn_reg <= rd_word_reg.snoise;
            end
            S_SQ1: acc_reg <= prod;
            S_SQ2:
            begin
                sq_val_reg  <= acc_reg[47:0] + prod[47:0];
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            S_SQRT:
            begin
                sq_val_reg  <= {sq_val_reg[45:0], 2'b00};
                sq_rem_reg  <= sq_ge ? 25'(sq_rem_sh - sq_trial) : sq_rem_sh[24:0];
                sq_root_reg <= {sq_root_reg[22:0], sq_ge};
            end
            S_DIV:
            begin
                dr_rem_reg <= dv_ge ? 24'(dv_rem_sh - {1'b0, dd_reg}) : dv_rem_sh[23:0];
                dv_reg     <= {dv_reg[38:0], dv_ge};
            end
            S_MAGD: mag_reg <= sq_root_reg;
            S_SMA:  acc_reg <= prod;
            S_SMB:  sm_reg  <= 24'((acc_reg + prod) >> 16);
            S_PA:   t_reg   <= prod[47:0];
            S_PB:   acc_reg <= prod;
            S_PC:   acc_reg <= acc_reg + {prod[39:0], 24'd0};
            S_PD:   t_reg   <= prod[47:0];
            S_PE:   acc_reg <= acc_reg + prod;
            S_PF:
            begin
                sq_val_reg  <= 48'((acc_reg + {prod[39:0], 24'd0}) >> 16);
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            S_PG: sm_reg <= sq_root_reg;
            S_MIN:
            begin
                ws_reg   <= ws_next;
                nmin_reg <= nmin_next;
                dv_reg     <= {mag_reg - nmin_next, 16'd0};
                dr_rem_reg <= '0;
                dd_reg     <= nmin_next;
            end
            S_NZ:
                noise_reg <= (prod[39:37] != 3'd0) ? '1 : prod[36:13];
            S_NSA: acc_reg <= prod;
            S_NSB: sn_reg  <= 24'((acc_reg + prod) >> 16);
            S_DRN:
            begin
                dv_reg     <= {sn_reg, 16'd0};
                dr_rem_reg <= '0;
                dd_reg     <= mag_reg;
            end
            S_RN:
            begin
                rn_reg     <= q_sat;
                dv_reg     <= {sm_reg, 16'd0};
                dr_rem_reg <= '0;
                dd_reg     <= mag_reg;
            end
            S_RS:
            begin
                rs_reg     <= q_sat;
                dv_reg     <= {sn_reg, 16'd0};
                dr_rem_reg <= '0;
                dd_reg     <= sm_reg;
            end
            S_RQ: rq_reg <= q_sat;
            S_GL:
            begin
                left_reg  <= lscale ? prod[47:16] : {16'd0, gain_floor_reg};
                // S(v) = 1 - v, floored at zero
                right_reg <= (rratio >= 32'h0001_0000) ? 17'd0
                             : 17'(ssg_pkg::Q16_ONE - rratio[16:0]);
            end
            S_GP:
            begin
                right_reg   <= '0;
                sq_val_reg  <= 48'(33'h1_0000_0000 - {1'b0, prod[31:0]});
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            S_GR: right_reg <= sq_root_reg[16:0];
            S_GM:
                gain_reg <= (gain_max > {15'd0, ssg_pkg::Q16_ONE}) ? ssg_pkg::Q16_ONE
                            : gain_max[16:0];
            S_OA: ore_reg <= in_reg.bin_re[23] ? -$signed(prod[39:16]) : $signed(prod[39:16]);
            S_OB: oim_reg <= in_reg.bin_im[23] ? -$signed(prod[39:16]) : $signed(prod[39:16]);
            S_R1: acc_reg <= prod;
            S_R2: acc_reg <= acc_reg + prod;
            S_R3: t_reg   <= prod[47:0];
            S_R4:
            begin
                // keep the previous output when the new one is louder
                if (acc_reg[48:0] > {1'b0, pn_prev})
                begin
                    ore_reg <= ws_reg.pout_re;
                    oim_reg <= ws_reg.pout_im;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_reg.out_re       <= ore_reg;
                    out_reg.out_im       <= oim_reg;
                    out_reg.gain_applied <= gain_reg;
                    out_reg.last_out     <= in_reg.last_bin;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.gain_applied <= ssg_pkg::Q16_ONE))
        else $error("gain above unity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("bin memory written while idle");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transfer accepted while busy");

    a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FC_LAST)
        else $error("frame counter past segment length");
`endif

endmodule
